### rtl/huffman_code_builder_top_macros.svh
// Assertion macros for the Huffman code builder.
// Used by huffman_code_builder_top; needs clk and rst_n in scope.
`ifndef HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, ignored during reset.
`define HCB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcb assertion failed");

// Next-cycle implication, ignored during reset.
`define HCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcb assertion failed");

`endif

### rtl/hcb_pkg.sv
// Shared constants and controller/datapath handshake types for the code builder.
// No dependencies.
package hcb_pkg;

  localparam int DEF_MAX_SYMBOLS = 32;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int SYM_W  = 5;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 31;

  // Controller to datapath
  typedef struct packed {
    logic load;      // input beat: store a leaf
    logic merge;     // merge the two lightest forest entries
    logic emit;      // capture a leaf into the output register
    logic descend;   // push right child, step to left child
    logic pop_rd;    // pop the stack, read data arrives next cycle
    logic pop_load;  // take the popped entry as current node
    logic finish;    // clear count and overflow flag
  } hcb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic single_sym;   // this beat leaves exactly one symbol
    logic merge_last;   // two entries left: this merge builds the root
    logic cur_leaf;     // current node is a leaf
    logic stack_empty;  // nothing left to pop
  } hcb_sts_t;

endpackage

### rtl/hcb_if.sv
// Valid/ready channel interfaces for weights in and codes out.
// Depends on hcb_pkg.
interface hcb_in_if #(parameter int WEIGHT_BITS = hcb_pkg::DEF_WEIGHT_BITS);
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   last_symbol;
  modport source (output valid, output weight, output last_symbol, input ready);
  modport sink   (input valid, input weight, input last_symbol, output ready);
endinterface

interface hcb_out_if;
  logic                      valid;
  logic                      ready;
  logic [hcb_pkg::SYM_W-1:0]  symbol;
  logic [hcb_pkg::LEN_W-1:0]  code_length;
  logic [hcb_pkg::CODE_W-1:0] code_bits;
  logic                      last_code;
  logic                      dropped;
  modport source (output valid, output symbol, output code_length, output code_bits,
                  output last_code, output dropped, input ready);
  modport sink   (input valid, input symbol, input code_length, input code_bits,
                  input last_code, input dropped, output ready);
endinterface

### rtl/hcb_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/hcb_ctrl.sv
// Controller FSM: load, merge rounds, tree walk and output handshake.
// Depends on hcb_pkg.
module hcb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              out_ready,
  input  hcb_pkg::hcb_sts_t sts,
  output logic              in_ready,
  output logic              out_valid,
  output hcb_pkg::hcb_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_MERGE = 6'b000010,
    S_VISIT = 6'b000100,
    S_DESC  = 6'b001000,
    S_OUT   = 6'b010000,
    S_POP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = sts.single_sym ? S_VISIT : S_MERGE;
          end
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (sts.merge_last) begin
          state_nxt = S_VISIT;
        end
      end
      S_VISIT: begin
        if (sts.cur_leaf) begin
          cmd.emit  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DESC;
        end
      end
      S_DESC: begin
        cmd.descend = 1'b1;
        state_nxt   = S_VISIT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.stack_empty) begin
            cmd.finish = 1'b1;
            state_nxt  = S_LOAD;
          end else begin
            cmd.pop_rd = 1'b1;
            state_nxt  = S_POP;
          end
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_VISIT;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

### rtl/hcb_dp.sv
// Datapath: sorted forest cells, child RAM, walk stack RAM and output register.
// Depends on hcb_pkg and hcb_ram.
module hcb_dp #(
  parameter int MAX_SYMBOLS = hcb_pkg::DEF_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = hcb_pkg::DEF_WEIGHT_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hcb_pkg::hcb_cmd_t           cmd,
  input  logic [WEIGHT_BITS-1:0]      in_weight,
  output hcb_pkg::hcb_sts_t           sts,
  output logic [hcb_pkg::SYM_W-1:0]   out_symbol,
  output logic [hcb_pkg::LEN_W-1:0]   out_code_length,
  output logic [hcb_pkg::CODE_W-1:0]  out_code_bits,
  output logic                        out_last_code,
  output logic                        out_dropped
);

  localparam int NW     = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int NODES  = 2 * MAX_SYMBOLS - 1;
  localparam int IW     = $clog2(NODES);
  localparam int CW     = $clog2(MAX_SYMBOLS + 1);
  localparam int AW     = $clog2(MAX_SYMBOLS);
  localparam int LW     = hcb_pkg::LEN_W;
  localparam int KW     = hcb_pkg::CODE_W;
  localparam int STK_W  = IW + LW + KW;

  // Forest cells kept sorted by weight, ties in forest order
  logic [NW-1:0] cell_w_r   [MAX_SYMBOLS];
  logic [IW-1:0] cell_i_r   [MAX_SYMBOLS];
  logic [NW-1:0] cell_w_nxt [MAX_SYMBOLS];
  logic [IW-1:0] cell_i_nxt [MAX_SYMBOLS];
  logic [NW-1:0] src_w      [MAX_SYMBOLS];
  logic [IW-1:0] src_i      [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] le;

  logic [CW-1:0] count_r, count_nxt, len_r, n_r, vl;
  logic          ovf_r;
  logic [IW-1:0] next_r, cur_r, new_i;
  logic [NW-1:0] new_w, sum_w;
  logic [LW-1:0] clen_r;
  logic [KW-1:0] code_r;
  logic [AW-1:0] sp_r;
  logic          store_leaf, cell_we;

  logic [2*IW-1:0]  child_rd;
  logic [STK_W-1:0] stk_wr, stk_rd;
  logic [AW-1:0]    stk_rd_addr;

  assign store_leaf = cmd.load && (count_r < CW'(MAX_SYMBOLS));
  assign count_nxt  = store_leaf ? CW'(count_r + 1'b1) : count_r;
  assign sum_w      = cell_w_r[0] + cell_w_r[1];
  assign new_w      = cmd.merge ? sum_w : NW'(in_weight);
  assign new_i      = cmd.merge ? next_r : IW'(count_r);
  assign vl         = cmd.merge ? CW'(len_r - CW'(2)) : count_r;
  assign cell_we    = store_leaf || cmd.merge;

  // Insertion row: each cell keeps, takes the new node, or shifts up
  for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
    if (i + 2 < MAX_SYMBOLS) begin : g_src
      assign src_w[i] = cmd.merge ? cell_w_r[i+2] : cell_w_r[i];
      assign src_i[i] = cmd.merge ? cell_i_r[i+2] : cell_i_r[i];
    end else begin : g_src_top
      assign src_w[i] = cell_w_r[i];
      assign src_i[i] = cell_i_r[i];
    end
    assign le[i] = (CW'(i) < vl) && (src_w[i] <= new_w);
    if (i == 0) begin : g_first
      assign cell_w_nxt[i] = le[i] ? src_w[i] : new_w;
      assign cell_i_nxt[i] = le[i] ? src_i[i] : new_i;
    end else begin : g_rest
      assign cell_w_nxt[i] = le[i] ? src_w[i] : (le[i-1] ? new_w : src_w[i-1]);
      assign cell_i_nxt[i] = le[i] ? src_i[i] : (le[i-1] ? new_i : src_i[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_w_r <= cell_w_nxt;
      cell_i_r <= cell_i_nxt;
    end
  end

  // Set bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      sp_r    <= '0;
    end else begin
      if (cmd.finish) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (cmd.load) begin
        count_r <= count_nxt;
        if (!store_leaf) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.descend) begin
        sp_r <= AW'(sp_r + 1'b1);
      end else if (cmd.pop_rd) begin
        sp_r <= AW'(sp_r - 1'b1);
      end
    end
  end

  // Merge counters and walk cursor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r  <= count_nxt;
      n_r    <= count_nxt;
      next_r <= IW'(count_nxt);
      cur_r  <= '0;
      clen_r <= '0;
      code_r <= '0;
    end else if (cmd.merge) begin
      len_r  <= CW'(len_r - 1'b1);
      next_r <= IW'(next_r + 1'b1);
      cur_r  <= next_r;
    end else if (cmd.descend) begin
      cur_r  <= child_rd[2*IW-1:IW];
      clen_r <= LW'(clen_r + 1'b1);
      code_r <= {code_r[KW-2:0], 1'b0};
    end else if (cmd.pop_load) begin
      cur_r  <= stk_rd[STK_W-1:LW+KW];
      clen_r <= stk_rd[LW+KW-1:KW];
      code_r <= stk_rd[KW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_symbol      <= hcb_pkg::SYM_W'(cur_r);
      out_code_length <= clen_r;
      out_code_bits   <= code_r;
      out_last_code   <= (sp_r == '0);
      out_dropped     <= ovf_r;
    end
  end

  // Children of merged nodes, {left, right}
  hcb_ram #(.WIDTH(2 * IW), .DEPTH(NODES)) u_child_ram (
    .clk     (clk),
    .wr_en   (cmd.merge),
    .wr_addr (next_r),
    .wr_data ({cell_i_r[0], cell_i_r[1]}),
    .rd_addr (cur_r),
    .rd_data (child_rd)
  );

  // Pending right subtrees of the walk
  assign stk_wr      = {child_rd[IW-1:0], LW'(clen_r + 1'b1), {code_r[KW-2:0], 1'b1}};
  assign stk_rd_addr = AW'(sp_r - 1'b1);

  hcb_ram #(.WIDTH(STK_W), .DEPTH(MAX_SYMBOLS)) u_stack_ram (
    .clk     (clk),
    .wr_en   (cmd.descend),
    .wr_addr (sp_r),
    .wr_data (stk_wr),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd)
  );

  assign sts.single_sym  = (count_r == '0);
  assign sts.merge_last  = (len_r == CW'(2));
  assign sts.cur_leaf    = (cur_r < IW'(n_r));
  assign sts.stack_empty = (sp_r == '0);

endmodule

### rtl/huffman_code_builder_top.sv
// Huffman code builder: weights in, one code per symbol out.
// Channels: in_ch carries weight and last_symbol; out_ch carries symbol, code_length,
// code_bits, last_code and dropped. Both are valid/ready; a beat moves when both are high.
// Weights load at one beat per cycle into a sorted row of forest cells; symbols are
// numbered in load order and those beyond MAX_SYMBOLS are dropped and flagged.
// The beat with last_symbol starts construction: n symbols take n-1 merges, each done
// in the insertion row. Then a left-first walk emits the codes: each internal node
// passes a child RAM read, then a descend; each leaf is captured and then sent as its
// output beat; each return to a pending right subtree takes a stack RAM read.
// Input is not ready from the last beat until the final code is taken.
// A receiver stall holds the current code in the output register; the walk waits.
// Reset is synchronous, active low, and returns the block to loading an empty set;
// the RAMs need no clearing, only entries written for the current set are read.
// Depends on hcb_pkg, hcb_if, hcb_ram, hcb_ctrl, hcb_dp and the macros header.
`include "huffman_code_builder_top_macros.svh"

module huffman_code_builder_top #(
  parameter int MAX_SYMBOLS = hcb_pkg::DEF_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = hcb_pkg::DEF_WEIGHT_BITS
) (
  input logic       clk,
  input logic       rst_n,
  hcb_in_if.sink    in_ch,
  hcb_out_if.source out_ch
);

  hcb_pkg::hcb_cmd_t cmd;
  hcb_pkg::hcb_sts_t sts;

  hcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_symbol),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  hcb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_weight       (in_ch.weight[WEIGHT_BITS-1:0]),
    .sts             (sts),
    .out_symbol      (out_ch.symbol),
    .out_code_length (out_ch.code_length),
    .out_code_bits   (out_ch.code_bits),
    .out_last_code   (out_ch.last_code),
    .out_dropped     (out_ch.dropped)
  );

  // Loading and emission never overlap
  `HCB_ASSERT_IMPL(a_no_overlap, out_ch.valid, !in_ch.ready)
  // Closing beat starts construction, input stops
  `HCB_ASSERT_NEXT(a_last_stops_input, in_ch.valid && in_ch.ready && in_ch.last_symbol,
                   !in_ch.ready)
  // After the final code the block loads again
  `HCB_ASSERT_NEXT(a_final_code_reloads, out_ch.valid && out_ch.ready && out_ch.last_code,
                   in_ch.ready)

endmodule
